FILE: hw/rtl/pup_pkg.sv
package pup_pkg;

  // Fixed field widths
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned DEPTH_W     = 2;
  localparam int unsigned RP_W        = 15;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 15;
  localparam int unsigned PIX_W       = 32;
  localparam int unsigned BYTE_W      = 8;

  // Sizing constants
  localparam int unsigned MAX_ROW_PIXELS  = 16384;
  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned ROW_W  = $clog2(MAX_ROW_PIXELS + 1);
  localparam int unsigned COL_W  = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
  localparam int unsigned PAL_AW = $clog2(PALETTE_ENTRIES);
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_CODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PIXELS  = 2'd2;

  // Colour types
  localparam logic [MODE_W-1:0] MODE_GRAY  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RGB   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PAL   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_GA    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RGBA  = 3'd6;

  // Item commands
  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_PAL_WR = 1'b1;

  localparam logic [7:0] OPAQUE = 8'hFF;

  typedef enum logic [1:0] {
    JOB_PAL_WR,
    JOB_WORD,
    JOB_GRAY,
    JOB_PAL
  } pup_job_kind_t;

  // One unit of work handed from the front to the back
  typedef struct packed {
    pup_job_kind_t        kind;
    logic [PIX_W-1:0]     word;     // finished pixel, or palette colour
    logic [BYTE_W-1:0]    data;     // packed samples, or palette index
    logic [DEPTH_W-1:0]   depth;
    logic [3:0]           count;    // pixels to emit, 1..8
    logic                 row_end;  // final pixel closes the row
    logic [BYTE_W-1:0]    filter;
  } pup_job_t;

endpackage

FILE: hw/rtl/pup_if.sv
interface pup_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  data_byte;
  logic [7:0]  entry_index;
  logic [31:0] entry_colour;

  modport source (output valid, cmd, data_byte, entry_index, entry_colour, input ready);
  modport sink   (input valid, cmd, data_byte, entry_index, entry_colour, output ready);
endinterface

interface pup_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] argb_pixel;
  logic [7:0]  row_filter;
  logic        row_end;
  logic        last;

  modport source (output valid, argb_pixel, row_filter, row_end, last, input ready);
  modport sink   (input valid, argb_pixel, row_filter, row_end, last, output ready);
endinterface

FILE: hw/rtl/pup_ram.sv
module pup_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/pup_front.sv
module pup_front import pup_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pup_in_if.sink                in_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  q_full,
  output logic                  q_push,
  output pup_job_t              q_job
);

  logic [MODE_W-1:0]  mode_r;
  logic [DEPTH_W-1:0] depth_r;
  logic [RP_W-1:0]    row_pixels_r;

  logic               expect_filter_r, expect_filter_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [7:0]         filter_r, filter_nxt;
  logic [23:0]        part_r, part_nxt;
  logic [1:0]         bip_r, bip_nxt;

  logic               accept;
  logic               mode_ok;
  logic               sub_byte;
  logic [ROW_W-1:0]   rowlen;
  logic [3:0]         cnt;
  logic [ROW_W:0]     col_sum;
  logic [ROW_W:0]     col_one;
  logic [ROW_W-1:0]   diff;
  logic               end_sub;
  logic               end_one;
  logic [2:0]         need;
  logic               complete;
  logic [PIX_W-1:0]   word;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_RGBA;
      depth_r      <= 2'd3;
      row_pixels_r <= RP_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLOUR_MODE: mode_r       <= cfg_wdata[MODE_W-1:0];
        CFG_DEPTH_CODE:  depth_r      <= cfg_wdata[DEPTH_W-1:0];
        CFG_ROW_PIXELS:  row_pixels_r <= cfg_wdata[RP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_pixels_r == '0) begin
      rowlen = ROW_W'(1);
    end else if (32'(row_pixels_r) > MAX_ROW_PIXELS) begin
      rowlen = ROW_W'(MAX_ROW_PIXELS);
    end else begin
      rowlen = ROW_W'(row_pixels_r);
    end
  end

  assign mode_ok  = (mode_r == MODE_GRAY) || (mode_r == MODE_RGB) || (mode_r == MODE_PAL) ||
                    (mode_r == MODE_GA) || (mode_r == MODE_RGBA);
  assign sub_byte = (mode_r == MODE_GRAY) || (mode_r == MODE_PAL);

  // Sub-byte samples: the byte yields cnt pixels unless the row closes first
  assign cnt     = 4'(4'd8 >> depth_r);
  assign col_sum = (ROW_W+1)'(col_r) + (ROW_W+1)'(cnt);
  assign col_one = (ROW_W+1)'(col_r) + (ROW_W+1)'(1);
  assign diff    = rowlen - ROW_W'(col_r);
  assign end_sub = col_sum >= {1'b0, rowlen};
  assign end_one = col_one >= {1'b0, rowlen};

  always_comb begin
    unique case (mode_r)
      MODE_RGB: need = 3'd3;
      MODE_GA:  need = 3'd2;
      default:  need = 3'd4;
    endcase
  end
  assign complete = (3'(bip_r) + 3'd1) >= need;

  always_comb begin
    unique case (mode_r)
      MODE_RGB: word = {OPAQUE, part_r[15:0], in_ch.data_byte};
      MODE_GA:  word = {in_ch.data_byte, part_r[7:0], part_r[7:0], part_r[7:0]};
      default:  word = {in_ch.data_byte, part_r};
    endcase
  end

  always_comb begin
    expect_filter_nxt = expect_filter_r;
    col_nxt           = col_r;
    filter_nxt        = filter_r;
    part_nxt          = part_r;
    bip_nxt           = bip_r;
    q_push            = 1'b0;
    q_job.kind        = JOB_WORD;
    q_job.word        = word;
    q_job.data        = in_ch.data_byte;
    q_job.depth       = depth_r;
    q_job.count       = 4'd1;
    q_job.row_end     = end_one;
    q_job.filter      = filter_r;

    if (accept) begin
      if (in_ch.cmd == CMD_PAL_WR) begin
        q_push      = 1'b1;
        q_job.kind  = JOB_PAL_WR;
        q_job.word  = in_ch.entry_colour;
        q_job.data  = in_ch.entry_index;
      end else if (mode_ok) begin
        if (expect_filter_r) begin
          filter_nxt        = in_ch.data_byte;
          expect_filter_nxt = 1'b0;
          col_nxt           = '0;
          part_nxt          = '0;
          bip_nxt           = '0;
        end else if (sub_byte) begin
          q_push        = 1'b1;
          q_job.kind    = (mode_r == MODE_PAL) ? JOB_PAL : JOB_GRAY;
          q_job.row_end = end_sub;
          if (!end_sub) begin
            q_job.count = cnt;
          end else if (end_one) begin
            q_job.count = 4'd1;
          end else begin
            q_job.count = diff[3:0];
          end
          if (end_sub) begin
            col_nxt           = '0;
            expect_filter_nxt = 1'b1;
          end else begin
            col_nxt = COL_W'(col_sum);
          end
        end else if (complete) begin
          q_push   = 1'b1;
          part_nxt = '0;
          bip_nxt  = '0;
          if (end_one) begin
            col_nxt           = '0;
            expect_filter_nxt = 1'b1;
          end else begin
            col_nxt = COL_W'(col_one);
          end
        end else begin
          part_nxt = {part_r[15:0], in_ch.data_byte};
          bip_nxt  = bip_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_filter_r <= 1'b1;
      col_r           <= '0;
      filter_r        <= '0;
      part_r          <= '0;
      bip_r           <= '0;
    end else begin
      expect_filter_r <= expect_filter_nxt;
      col_r           <= col_nxt;
      filter_r        <= filter_nxt;
      part_r          <= part_nxt;
      bip_r           <= bip_nxt;
    end
  end

endmodule

FILE: hw/rtl/pup_fifo.sv
module pup_fifo import pup_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  pup_job_t push_job,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output pup_job_t head_job
);

  pup_job_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   cnt_r;
  logic            do_push, do_pop;

  assign full       = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_AW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + (Q_AW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (Q_AW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: hw/rtl/pup_back.sv
module pup_back import pup_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     head_valid,
  input  pup_job_t head_job,
  output logic     pop,
  pup_out_if.source out_ch
);

  logic [2:0]        k_r, k_nxt;
  logic              out_valid_r;
  logic [PIX_W-1:0]  pix_r;
  logic              use_ram_r, pal_zero_r;
  logic [7:0]        filter_r;
  logic              row_end_r, last_r;

  logic              out_free;
  logic              is_pix;
  logic              emit;
  logic              final_pix;
  logic [2:0]        kb;
  logic [3:0]        bits;
  logic [7:0]        shifted;
  logic [7:0]        sample;
  logic              pal_in_range;
  logic              ram_we;
  logic [PIX_W-1:0]  ram_rdata;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign is_pix    = head_job.kind != JOB_PAL_WR;
  assign emit      = head_valid && is_pix && out_free;
  assign final_pix = (4'(k_r) + 4'd1) == head_job.count;
  assign pop       = head_valid && (!is_pix || (out_free && final_pix));
  assign ram_we    = head_valid && !is_pix &&
                     ({1'b0, head_job.data} < 9'(PALETTE_ENTRIES));

  // Pick sample k, most significant first
  assign bits    = 4'(4'd1 << head_job.depth);
  assign kb      = 3'(k_r << head_job.depth);
  assign shifted = 8'(head_job.data << kb);
  assign sample  = 8'(shifted >> (4'd8 - bits));
  assign pal_in_range = {1'b0, sample} < 9'(PALETTE_ENTRIES);

  pup_ram #(
    .WIDTH (PIX_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_job.data[PAL_AW-1:0]),
    .wdata (head_job.word),
    .re    (emit && head_job.kind == JOB_PAL),
    .raddr (sample[PAL_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    k_nxt = k_r;
    if (emit) begin
      k_nxt = final_pix ? 3'd0 : k_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      k_r <= k_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      unique case (head_job.kind)
        JOB_GRAY: pix_r <= {OPAQUE, sample, sample, sample};
        default:  pix_r <= head_job.word;
      endcase
      use_ram_r  <= head_job.kind == JOB_PAL;
      pal_zero_r <= !pal_in_range;
      filter_r   <= head_job.filter;
      row_end_r  <= final_pix && head_job.row_end;
      last_r     <= final_pix;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.argb_pixel = use_ram_r ? (pal_zero_r ? '0 : ram_rdata) : pix_r;
  assign out_ch.row_filter = filter_r;
  assign out_ch.row_end    = row_end_r;
  assign out_ch.last       = last_r;

endmodule

FILE: hw/rtl/png_scanline_pixel_unpacker_core.sv
// PNG scanline pixel unpacker.
// in_ch carries one transaction per decompressed image byte (cmd 0) or per
// palette write (cmd 1, entry_index / entry_colour). out_ch carries one
// transaction per ARGB pixel with the row's filter byte, a row_end flag and a
// last flag on the final pixel caused by a byte. cfg_we / cfg_index /
// cfg_wdata write colour_mode (0), depth_code (1) and row_pixels (2); write
// them only while no transaction is in flight.
// Path: an accepted byte's job is written into the job queue, then the back
// stage emits it into the output register that drives out_ch.valid.
// Throughput: one byte per cycle while out_ch accepts, for 8-bit gray/palette,
// RGB, gray+alpha and RGBA. A 1, 2 or 4 bit byte holds the emit stage for
// up to 8, 4 or 2 pixels, one per unstalled cycle (fewer when the row closes
// inside the byte); the four-entry job queue then fills and in_ch.ready drops.
// Palette writes pass through the emit stage without a pixel and keep stream order.
// Reset (rst_n low, synchronous) restores the register defaults, expects a
// filter byte next and empties the queue; palette contents are kept.
// When out_ch stalls, the output register holds, the queue absorbs up to four
// more jobs and then back-pressure reaches in_ch.
module png_scanline_pixel_unpacker_core import pup_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pup_in_if.sink                in_ch,
  pup_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  pup_job_t push_job, head_job;
  logic     q_push, q_full, q_pop, head_valid;

  // Front: classify bytes, track row position, assemble multi-byte pixels
  pup_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  // Decouple the byte rate from the pixel rate
  pup_fifo u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Back: emit one pixel per cycle while out_ch accepts, own the palette memory
  pup_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule

FILE: hw/rtl/pup_checker.sv
module pup_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_argb,
  input logic        out_row_end,
  input logic        out_last
);

  // Hold a stalled transaction
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  a_pixel_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_argb))
    else $error("pixel changed while stalled");

  // A row can only close on the final pixel of a byte
  a_row_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row_end |-> out_last)
    else $error("row_end without last");

  // Drop any output after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind png_scanline_pixel_unpacker_core pup_checker u_pup_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_argb    (out_ch.argb_pixel),
  .out_row_end (out_ch.row_end),
  .out_last    (out_ch.last)
);
